[sv/llp_pkg.sv]
// shared types, constants and helpers for the coordinate text parser
package llp_pkg;

  localparam int WHOLE_BITS      = 20;
  localparam int FRAC_BITS       = 30;
  localparam int CNT_BITS        = 4;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int OUT_BITS        = 50;
  localparam int FRAC_OUT_BITS   = 28;
  localparam int IDEG_BITS       = 22;
  localparam int REM_BITS        = 43;
  localparam int DEN_SHIFT       = 13;
  localparam int SCL_BITS        = REM_BITS + FRAC_OUT_BITS - DEN_SHIFT;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_UW    = 8'h57;
  localparam logic [7:0] CH_LW    = 8'h77;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_LS    = 8'h73;

  localparam logic [WHOLE_BITS-1:0] WHOLE_MAX = {WHOLE_BITS{1'b1}};
  localparam logic [REM_BITS-1:0]   DENOM     = 43'd3600000000000;
  localparam logic [31:0]           NANO      = 32'd1000000000;
  localparam logic [31:0] SEC_PER_DEG = 32'd3600;
  localparam logic [31:0] SEC_PER_MIN = 32'd60;
  // floor(2^43 / 3600)
  localparam logic [31:0] RECIP_SEC   = 32'd2443359172;
  // floor(2^70 / 3.6e12)
  localparam logic [31:0] RECIP_DEN   = 32'd327942116;
  // 3.6e12 / 2^13
  localparam logic [31:0] DEN_ODD     = 32'd439453125;

  typedef struct packed {
    logic [2:0][WHOLE_BITS-1:0] whole;
    logic [2:0][FRAC_BITS-1:0]  frac;
    logic [2:0][CNT_BITS-1:0]   cnt;
    logic                       neg;
    logic                       ovf;
  } snapshot_t;

  // scale for a fraction with c digits: 10^(9-c)
  function automatic logic [29:0] pow10_scale(input logic [CNT_BITS-1:0] c);
    logic [29:0] r;
    unique case (c)
      4'd0:    r = 30'd1000000000;
      4'd1:    r = 30'd100000000;
      4'd2:    r = 30'd10000000;
      4'd3:    r = 30'd1000000;
      4'd4:    r = 30'd100000;
      4'd5:    r = 30'd10000;
      4'd6:    r = 30'd1000;
      4'd7:    r = 30'd100;
      4'd8:    r = 30'd10;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

endpackage

[sv/llp_front.sv]
// character intake: splits the text into pieces and queues a snapshot on NUL
module llp_front import llp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       q_full,
  output logic       q_push,
  output snapshot_t  q_data
);

  logic [2:0][WHOLE_BITS-1:0] whole_r, whole_nxt;
  logic [2:0][FRAC_BITS-1:0]  frac_r, frac_nxt;
  logic [2:0][CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [1:0] piece_r, piece_nxt;
  logic       in_frac_r, in_frac_nxt;
  logic       neg_r, neg_nxt;
  logic       sep_r, sep_nxt;
  logic       ovf_r, ovf_nxt;
  logic       acc_ok;
  logic [3:0] digit;
  logic [WHOLE_BITS+3:0] wv;
  logic [FRAC_BITS+3:0]  fv;

  assign in_ready = !q_full;
  assign acc_ok   = in_valid && in_ready;
  assign digit    = in_char_code[3:0] - CH_ZERO[3:0];
  assign q_push   = acc_ok && (in_char_code == CH_NUL);
  assign q_data   = '{whole: whole_r, frac: frac_r, cnt: cnt_r, neg: neg_r, ovf: ovf_r};

  always_comb begin
    whole_nxt   = whole_r;
    frac_nxt    = frac_r;
    cnt_nxt     = cnt_r;
    piece_nxt   = piece_r;
    in_frac_nxt = in_frac_r;
    neg_nxt     = neg_r;
    sep_nxt     = sep_r;
    ovf_nxt     = ovf_r;
    wv          = '0;
    fv          = '0;
    if (acc_ok) begin
      priority if (in_char_code == CH_NUL) begin
        whole_nxt   = '0;
        frac_nxt    = '0;
        cnt_nxt     = '0;
        piece_nxt   = '0;
        in_frac_nxt = 1'b0;
        neg_nxt     = 1'b0;
        sep_nxt     = 1'b0;
        ovf_nxt     = 1'b0;
      end else if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) begin
        sep_nxt = 1'b0;
        if (piece_r == 2'd3) begin
          ovf_nxt = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (piece_r == 2'(k)) begin
              if (in_frac_r) begin
                if (cnt_r[k] < CNT_BITS'(MAX_FRAC_DIGITS)) begin
                  fv = {1'b0, frac_r[k], 3'b000} + {3'b000, frac_r[k], 1'b0}
                       + (FRAC_BITS+4)'(digit);
                  frac_nxt[k] = fv[FRAC_BITS-1:0];
                  cnt_nxt[k]  = cnt_r[k] + CNT_BITS'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end else begin
                wv = {1'b0, whole_r[k], 3'b000} + {3'b000, whole_r[k], 1'b0}
                     + (WHOLE_BITS+4)'(digit);
                if (wv > (WHOLE_BITS+4)'(WHOLE_MAX)) begin
                  whole_nxt[k] = WHOLE_MAX;
                  ovf_nxt      = 1'b1;
                end else begin
                  whole_nxt[k] = wv[WHOLE_BITS-1:0];
                end
              end
            end
          end
        end
      end else if (in_char_code == CH_POINT) begin
        sep_nxt = 1'b0;
        if (in_frac_r) ovf_nxt = 1'b1;
        else in_frac_nxt = 1'b1;
      end else if (in_char_code == CH_UW || in_char_code == CH_LW ||
                   in_char_code == CH_US || in_char_code == CH_LS) begin
        neg_nxt = 1'b1;
        sep_nxt = 1'b0;
      end else if (!sep_r) begin
        if (piece_r != 2'd3) piece_nxt = piece_r + 2'd1;
        in_frac_nxt = 1'b0;
        sep_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r   <= '0;
      frac_r    <= '0;
      cnt_r     <= '0;
      piece_r   <= '0;
      in_frac_r <= 1'b0;
      neg_r     <= 1'b0;
      sep_r     <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      whole_r   <= whole_nxt;
      frac_r    <= frac_nxt;
      cnt_r     <= cnt_nxt;
      piece_r   <= piece_nxt;
      in_frac_r <= in_frac_nxt;
      neg_r     <= neg_nxt;
      sep_r     <= sep_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

[sv/llp_fifo.sv]
// two-entry snapshot queue between intake and conversion
module llp_fifo import llp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  snapshot_t wr_data,
  output logic      full,
  input  logic      pop,
  output logic      rd_valid,
  output snapshot_t rd_data
);

  snapshot_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[sv/llp_back.sv]
// conversion: 32x32 multiply sequence with reciprocal divisions by 3600 and 3.6e12
module llp_back import llp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  snapshot_t           q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_degrees_fixed,
  output logic                out_overflow
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [4:0]               step_r, step_nxt;
  snapshot_t                snap_r;
  logic [31:0]              secs_r, secs_nxt;
  logic [REM_BITS-1:0]      fr_r, fr_nxt;
  logic [REM_BITS-1:0]      rem_r, rem_nxt;
  logic [IDEG_BITS-1:0]     ideg_r, ideg_nxt;
  logic [FRAC_OUT_BITS-1:0] fbits_r, fbits_nxt;
  logic [31:0]              frem_r, frem_nxt;
  logic [63:0]              prod_r, prod_nxt;
  logic [SCL_BITS-1:0]      fdiff;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]      out_deg_r;
  logic                     out_ovf_r;
  logic [31:0]              mul_a, mul_b;
  logic                     load_out;
  logic                     sat;
  logic [OUT_BITS-1:0]      mag, res;

  assign q_pop             = (state_r == ST_IDLE) && q_valid;
  assign load_out          = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign out_valid         = out_valid_r;
  assign out_degrees_fixed = out_deg_r;
  assign out_overflow      = out_ovf_r;
  assign prod_nxt          = {32'b0, mul_a} * {32'b0, mul_b};
  // remainder of the fraction estimate, in units of 2^-15 of 3.6e12 / 2^13
  assign fdiff             = {rem_r, {(FRAC_OUT_BITS-DEN_SHIFT){1'b0}}} - prod_r[SCL_BITS-1:0];
  assign sat               = ideg_r[IDEG_BITS-1];
  assign mag               = sat ? {1'b0, {(OUT_BITS-1){1'b1}}}
                                 : {1'b0, ideg_r[IDEG_BITS-2:0], fbits_r};
  assign res               = snap_r.neg ? (OUT_BITS'(0) - mag) : mag;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    secs_nxt  = secs_r;
    fr_nxt    = fr_r;
    rem_nxt   = rem_r;
    ideg_nxt  = ideg_r;
    fbits_nxt = fbits_r;
    frem_nxt  = frem_r;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_CALC;
          step_nxt  = '0;
        end
      end
      ST_CALC: begin
        step_nxt = step_r + 5'd1;
        unique case (step_r)
          // whole seconds
          5'd0: begin
            mul_a = 32'(snap_r.whole[0]);
            mul_b = SEC_PER_DEG;
          end
          5'd1: begin
            secs_nxt = prod_r[31:0] + 32'(snap_r.whole[2]);
            mul_a    = 32'(snap_r.whole[1]);
            mul_b    = SEC_PER_MIN;
          end
          // fractions in nano arc seconds
          5'd2: begin
            secs_nxt = secs_r + prod_r[31:0];
            mul_a    = 32'(snap_r.frac[0]);
            mul_b    = 32'(pow10_scale(snap_r.cnt[0]));
          end
          5'd3: begin
            mul_a = prod_r[31:0];
            mul_b = SEC_PER_DEG;
          end
          5'd4: begin
            fr_nxt = prod_r[REM_BITS-1:0];
            mul_a  = 32'(snap_r.frac[1]);
            mul_b  = 32'(pow10_scale(snap_r.cnt[1]));
          end
          5'd5: begin
            mul_a = prod_r[31:0];
            mul_b = SEC_PER_MIN;
          end
          5'd6: begin
            fr_nxt = fr_r + prod_r[REM_BITS-1:0];
            mul_a  = 32'(snap_r.frac[2]);
            mul_b  = 32'(pow10_scale(snap_r.cnt[2]));
          end
          5'd7: begin
            fr_nxt = fr_r + prod_r[REM_BITS-1:0];
            mul_a  = secs_r;
            mul_b  = RECIP_SEC;
          end
          // degree estimate is exact or one low
          5'd8: begin
            ideg_nxt = {1'b0, prod_r[63:43]};
            mul_a    = {11'b0, prod_r[63:43]};
            mul_b    = SEC_PER_DEG;
          end
          5'd9: begin
            rem_nxt = {{(REM_BITS-32){1'b0}}, secs_r - prod_r[31:0]};
          end
          5'd10: begin
            if (rem_r >= REM_BITS'(SEC_PER_DEG)) begin
              rem_nxt  = rem_r - REM_BITS'(SEC_PER_DEG);
              ideg_nxt = ideg_r + IDEG_BITS'(1);
            end
          end
          5'd11: begin
            mul_a = rem_r[31:0];
            mul_b = NANO;
          end
          5'd12: begin
            rem_nxt = prod_r[REM_BITS-1:0] + fr_r;
          end
          // remainder stays below three times 3.6e12
          5'd13, 5'd14: begin
            if (rem_r >= DENOM) begin
              rem_nxt  = rem_r - DENOM;
              ideg_nxt = ideg_r + IDEG_BITS'(1);
            end
          end
          // fraction bits: estimate up to two low from the top 32 remainder bits
          5'd15: begin
            mul_a = rem_r[41:10];
            mul_b = RECIP_DEN;
          end
          5'd16: begin
            fbits_nxt = prod_r[59:32];
            mul_a     = {4'b0, prod_r[59:32]};
            mul_b     = DEN_ODD;
          end
          5'd17: begin
            frem_nxt = fdiff[31:0];
          end
          default: begin
            if (frem_r >= {DEN_ODD[30:0], 1'b0}) begin
              fbits_nxt = fbits_r + FRAC_OUT_BITS'(2);
            end else if (frem_r >= DEN_ODD) begin
              fbits_nxt = fbits_r + FRAC_OUT_BITS'(1);
            end
            step_nxt  = '0;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) snap_r <= q_data;
    secs_r  <= secs_nxt;
    fr_r    <= fr_nxt;
    rem_r   <= rem_nxt;
    ideg_r  <= ideg_nxt;
    fbits_r <= fbits_nxt;
    frem_r  <= frem_nxt;
    prod_r  <= prod_nxt;
    if (load_out) begin
      out_deg_r <= res;
      out_ovf_r <= snap_r.ovf | sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/latlong_text_parser.sv]
// top level of the coordinate text to signed decimal degrees parser
// usage:
//   in channel: one ASCII character per transaction on in_char_code; a NUL
//   ends the text. characters are taken one per cycle while the two-entry
//   snapshot queue has room.
//   out channel: one transaction per NUL, out_degrees_fixed in Q21.28 two's
//   complement and out_overflow for any correction seen in that text.
// conversion: with the converter idle, the snapshot of a NUL is popped from
//   the queue, a 19-step sequence of 32x32 multiplies with reciprocal
//   divisions by 3600 and 3.6e12 runs, and the result loads the output.
// throughput: characters at one per cycle while the queue has room; texts
//   convert one at a time; intake stalls only when two texts are queued.
// reset: synchronous, active low; clears all pieces, flags, the queue and the
//   output valid flag.
// stall: while out_ready is low the result holds in the output register, the
//   converter waits with its next result, and intake runs on until the queue
//   fills.
module latlong_text_parser import llp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_degrees_fixed,
  output logic                out_overflow
);

  snapshot_t push_data, pop_data;
  logic      q_push, q_pop, q_full, q_valid;

  llp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  llp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (push_data),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (pop_data)
  );

  llp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (pop_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_degrees_fixed (out_degrees_fixed),
    .out_overflow      (out_overflow)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("snapshot pushed into full queue");

  a_nul_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_char_code == CH_NUL) |=> q_valid)
    else $error("terminated text missing from queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
